[rtl/sep_pkg.sv]
// ----------------------------------------------------------------------------
// sep_pkg: shared types and constants
// Operation codes and the request word of the serial multiply/divide unit,
// plus the configuration register indexes of the smoothed-error PID block.
// ----------------------------------------------------------------------------
package sep_pkg;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} sep_op_t;

	// request to the serial unit: magnitudes in, sign of the result applied at the end
	typedef struct packed {
		sep_op_t      op;
		logic         neg;
		logic [47:0]  a_mag;
		logic [15:0]  b_mag;
	} sep_req_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_GAIN_P          = 3'd0;
	localparam cfg_idx_t REG_GAIN_I          = 3'd1;
	localparam cfg_idx_t REG_GAIN_D          = 3'd2;
	localparam cfg_idx_t REG_SMOOTHING_COUNT = 3'd3;
	localparam cfg_idx_t REG_LOOP_RATE       = 3'd4;

endpackage

[rtl/sep_if.sv]
// ----------------------------------------------------------------------------
// sep_if: valid/ready channels of the smoothed-error PID block
// Input channel carries an error sample or a clear request, output channel
// carries the controller drive value.
// ----------------------------------------------------------------------------
interface sep_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] error_sample;
	logic               clear;

	modport source (output valid, error_sample, clear, input ready);
	modport sink   (input valid, error_sample, clear, output ready);
endinterface

interface sep_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;

	modport source (output valid, drive, input ready);
	modport sink   (input valid, drive, output ready);
endinterface

[rtl/sep_muldiv.sv]
// ----------------------------------------------------------------------------
// sep_muldiv: serial multiply / divide unit
// Unsigned shift-add multiply (16 steps) or restoring divide giving a 32-bit
// quotient (32 steps), with the result sign applied on the way out.
// ----------------------------------------------------------------------------
module sep_muldiv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sep_pkg::sep_req_t  req,
	output logic               done,
	output logic signed [64:0] res
);
	import sep_pkg::*;

	localparam logic [5:0] MUL_STEPS = 6'd16;
	localparam logic [5:0] DIV_STEPS = 6'd32;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	sep_op_t     op_q;
	logic        neg_q;
	logic [47:0] a_q;
	logic [15:0] b_q;
	logic [63:0] acc_q;
	logic [31:0] mq_q;
	logic [15:0] rem_q;

	logic [16:0] trial;
	logic [16:0] trial_sub;
	logic        ge;
	logic [64:0] mag_ext;

	always_comb begin
		trial     = {rem_q, mq_q[31]};
		trial_sub = trial - {1'b0, b_q};
		ge        = (trial >= {1'b0, b_q});
		mag_ext   = {1'b0, acc_q};
	end

	assign res  = signed'(neg_q ? (65'd0 - mag_ext) : mag_ext);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_MUL) ? MUL_STEPS : DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= req.op;
			neg_q <= req.neg;
			a_q   <= req.a_mag;
			b_q   <= req.b_mag;
			acc_q <= '0;
			if (req.op == OP_MUL) begin
				mq_q  <= {req.b_mag, 16'd0};
				rem_q <= '0;
			end else begin
				// upper dividend bits are below the divisor, so 32 quotient bits suffice
				mq_q  <= req.a_mag[31:0];
				rem_q <= req.a_mag[47:32];
			end
		end else if (busy_q) begin
			mq_q <= {mq_q[30:0], 1'b0};
			if (op_q == OP_MUL) begin
				acc_q <= {acc_q[62:0], 1'b0} + (mq_q[31] ? {16'd0, a_q} : 64'd0);
			end else begin
				acc_q <= {acc_q[62:0], ge};
				rem_q <= ge ? trial_sub[15:0] : trial[15:0];
			end
		end
	end

endmodule

[rtl/smoothed_error_pid.sv]
// ----------------------------------------------------------------------------
// smoothed_error_pid: PID controller on a running average of the error
// Averages the error sample, integrates and differentiates the average and
// forms a saturated P+I+D drive value.
// ----------------------------------------------------------------------------
// Usage:
//   sample: valid/ready input channel, one error sample (Q8.8) or a clear
//   request per transaction. result: valid/ready output channel, one drive
//   value (Q16.16) per non-clear sample. cfg_we/cfg_index/cfg_data write the
//   gains, the smoothing count and the loop rate; write them only while idle.
//   A sample is worked through the one serial multiply/divide unit: five
//   16-step multiplies and two 32-step divides, one after another, then an
//   output step that loads its result into the output register; only then
//   is the next sample taken.
//   A clear request zeroes the mean and the integral and produces no result.
//   The output register holds a finished result until the receiver takes it;
//   a new sample may be accepted meanwhile, but its result waits in the
//   final step until the register is free.
//   Reset empties the output register, returns to idle, zeroes the mean, the
//   integral, the gains and the smoothing count, and sets the loop rate to one.
// ----------------------------------------------------------------------------
module smoothed_error_pid (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  sep_pkg::cfg_idx_t           cfg_index,
	input  logic [sep_pkg::CFG_DATA_W-1:0] cfg_data,
	sep_in_if.sink                      sample,
	sep_out_if.source                   result
);
	import sep_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL_N = 4'd1;
	localparam logic [3:0] ST_DIV_N = 4'd2;
	localparam logic [3:0] ST_MUL_R = 4'd3;
	localparam logic [3:0] ST_DIV_R = 4'd4;
	localparam logic [3:0] ST_MUL_P = 4'd5;
	localparam logic [3:0] ST_MUL_I = 4'd6;
	localparam logic [3:0] ST_MUL_D = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	localparam logic signed [47:0] INT48_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] INT48_MIN = {1'b1, {47{1'b0}}};
	localparam logic signed [31:0] INT32_MAX = {1'b0, {31{1'b1}}};
	localparam logic signed [31:0] INT32_MIN = {1'b1, {31{1'b0}}};

	// configuration
	logic signed [15:0] gain_p_q;
	logic signed [15:0] gain_i_q;
	logic signed [15:0] gain_d_q;
	logic [7:0]         smoothing_count_q;
	logic [15:0]        loop_rate_q;

	// control and state
	logic [3:0]         state_q;
	logic               issued_q;
	logic               out_valid_q;
	logic signed [31:0] mean_q;
	logic signed [47:0] integ_q;

	// working registers
	logic signed [15:0] err_q;
	logic signed [40:0] num_q;
	logic signed [31:0] mean_new_q;
	logic signed [32:0] diff_q;
	logic signed [48:0] deriv_q;
	logic signed [65:0] acc_q;
	logic signed [31:0] drive_q;

	logic               in_fire;
	logic               op_state;
	logic               unit_start;
	logic               unit_done;
	logic signed [64:0] unit_res;
	sep_req_t           unit_req;

	logic signed [48:0] opnd;
	logic [48:0]        opnd_neg;
	logic [15:0]        b_val;
	logic               b_neg;
	logic [15:0]        rate_eff;
	logic [15:0]        gp_mag, gi_mag, gd_mag;
	logic signed [48:0] isum;
	logic signed [47:0] isum_sat;
	logic signed [65:0] acc_adj;
	logic signed [57:0] acc_div;
	logic signed [31:0] drive_sat;
	logic               out_free;

	assign in_fire      = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);
	assign result.valid = out_valid_q;
	assign result.drive = drive_q;
	assign out_free     = !out_valid_q || result.ready;

	assign op_state   = (state_q != ST_IDLE) && (state_q != ST_OUT);
	assign unit_start = op_state && !issued_q;

	always_comb begin
		rate_eff = (loop_rate_q == 16'd0) ? 16'd1 : loop_rate_q;
		gp_mag   = gain_p_q[15] ? 16'(-gain_p_q) : gain_p_q;
		gi_mag   = gain_i_q[15] ? 16'(-gain_i_q) : gain_i_q;
		gd_mag   = gain_d_q[15] ? 16'(-gain_d_q) : gain_d_q;
	end

	// operand selection for the serial unit
	always_comb begin
		opnd  = '0;
		b_val = '0;
		b_neg = 1'b0;
		unit_req.op = OP_MUL;
		unique case (state_q)
			ST_MUL_N: begin
				opnd  = 49'(mean_q);
				b_val = {8'd0, smoothing_count_q};
			end
			ST_DIV_N: begin
				opnd        = 49'(num_q);
				b_val       = 16'({1'b0, smoothing_count_q} + 9'd1);
				unit_req.op = OP_DIV;
			end
			ST_MUL_R: begin
				opnd  = 49'(diff_q);
				b_val = rate_eff;
			end
			ST_DIV_R: begin
				opnd        = 49'(mean_new_q);
				b_val       = rate_eff;
				unit_req.op = OP_DIV;
			end
			ST_MUL_P: begin
				opnd  = 49'(mean_new_q);
				b_val = gp_mag;
				b_neg = gain_p_q[15];
			end
			ST_MUL_I: begin
				opnd  = 49'(integ_q);
				b_val = gi_mag;
				b_neg = gain_i_q[15];
			end
			ST_MUL_D: begin
				opnd  = deriv_q;
				b_val = gd_mag;
				b_neg = gain_d_q[15];
			end
			default: begin
				opnd  = '0;
				b_val = '0;
			end
		endcase
		opnd_neg       = 49'd0 - opnd;
		unit_req.a_mag = opnd[48] ? opnd_neg[47:0] : opnd[47:0];
		unit_req.b_mag = b_val;
		unit_req.neg   = opnd[48] ^ b_neg;
	end

	sep_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.req    (unit_req),
		.done   (unit_done),
		.res    (unit_res)
	);

	// integral update with 48-bit saturation
	always_comb begin
		isum = {integ_q[47], integ_q} + {{17{unit_res[31]}}, unit_res[31:0]};
		if (isum[48] != isum[47]) begin
			isum_sat = isum[48] ? INT48_MIN : INT48_MAX;
		end else begin
			isum_sat = isum[47:0];
		end
	end

	// divide by 256 toward zero, then saturate to 32 bits
	always_comb begin
		acc_adj = acc_q + (acc_q[65] ? 66'sd255 : 66'sd0);
		acc_div = acc_adj[65:8];
		if ((&acc_div[57:31]) || !(|acc_div[57:31])) begin
			drive_sat = acc_div[31:0];
		end else begin
			drive_sat = acc_div[57] ? INT32_MIN : INT32_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q          <= '0;
			gain_i_q          <= '0;
			gain_d_q          <= '0;
			smoothing_count_q <= '0;
			loop_rate_q       <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:          gain_p_q          <= cfg_data;
				REG_GAIN_I:          gain_i_q          <= cfg_data;
				REG_GAIN_D:          gain_d_q          <= cfg_data;
				REG_SMOOTHING_COUNT: smoothing_count_q <= cfg_data[7:0];
				REG_LOOP_RATE:       loop_rate_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			mean_q      <= '0;
			integ_q     <= '0;
		end else begin
			if (unit_start) begin
				issued_q <= 1'b1;
			end else if (unit_done) begin
				issued_q <= 1'b0;
			end

			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (sample.clear) begin
							mean_q  <= '0;
							integ_q <= '0;
						end else begin
							state_q <= ST_MUL_N;
						end
					end
				end
				ST_MUL_N: if (unit_done) state_q <= ST_DIV_N;
				ST_DIV_N: if (unit_done) state_q <= ST_MUL_R;
				ST_MUL_R: if (unit_done) state_q <= ST_DIV_R;
				ST_DIV_R: begin
					if (unit_done) begin
						integ_q <= isum_sat;
						state_q <= ST_MUL_P;
					end
				end
				ST_MUL_P: if (unit_done) state_q <= ST_MUL_I;
				ST_MUL_I: if (unit_done) state_q <= ST_MUL_D;
				ST_MUL_D: if (unit_done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						mean_q  <= mean_new_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q <= sample.error_sample;
		end
		if (unit_done) begin
			unique case (state_q)
				ST_MUL_N: num_q <= unit_res[40:0] + {{17{err_q[15]}}, err_q, 8'd0};
				ST_DIV_N: begin
					mean_new_q <= unit_res[31:0];
					diff_q     <= {unit_res[31], unit_res[31:0]} - {mean_q[31], mean_q};
				end
				ST_MUL_R: deriv_q <= unit_res[48:0];
				ST_MUL_P: acc_q   <= {unit_res[64], unit_res};
				ST_MUL_I: acc_q   <= acc_q + {unit_res[64], unit_res};
				ST_MUL_D: acc_q   <= acc_q + {unit_res[64], unit_res};
				default: ;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			drive_q <= drive_sat;
		end
	end

endmodule

[rtl/sep_checker.sv]
// ----------------------------------------------------------------------------
// sep_checker: port-level checks for the smoothed-error PID block
// Watches the sample and result channels and the sequencing seen from outside.
// ----------------------------------------------------------------------------
module sep_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_clear,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_drive
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_drive))
		else $error("result changed while stalled");

	// a normal sample keeps the block busy
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_clear |=> !in_ready)
		else $error("block ready right after a sample transaction");

	// a clear request never produces a result
	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_clear && !out_valid |=> !out_valid)
		else $error("result after a clear transaction");

	// a result only appears at the end of a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind smoothed_error_pid sep_checker u_sep_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.in_clear  (sample.clear),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_drive (result.drive)
);
